### sv/iaf_pkg.sv
// ----------------------------------------------------------------------------
// iaf_pkg - shared types and constants of the integer to ascii formatter
// Request kinds, digit shift register control and status words, ascii
// constants and the digit to character mapping.
// ----------------------------------------------------------------------------
package iaf_pkg;

    // field widths
    localparam int REQ_BITS     = 3;
    localparam int VALUE_BITS   = 64;
    localparam int CHAR_BITS    = 8;
    localparam int COUNT_BITS   = 31;
    localparam int BIN_BITS     = 32;
    localparam int DEC_DIGITS   = 10;
    localparam int HEX_DIGITS   = BIN_BITS / 4;
    localparam int BCD_BITS     = DEC_DIGITS * 4;
    localparam int IN_TDATA_BITS  = VALUE_BITS;
    localparam int OUT_TDATA_BITS = ((CHAR_BITS + COUNT_BITS + 7) / 8) * 8;

    // default width of a pointer
    localparam int POINTER_BITS_DEF = 64;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // ascii characters
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] ASCII_X     = 8'h78;
    localparam logic [CHAR_BITS-1:0] ASCII_UC_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] ASCII_LC_A  = 8'h61;

    // request kinds as carried in the input tuser
    typedef enum logic [REQ_BITS-1:0] {
        RK_SDEC = 3'd0,
        RK_UDEC = 3'd1,
        RK_HEXL = 3'd2,
        RK_HEXU = 3'd3,
        RK_PTR  = 3'd4
    } t_req_kind;

    // digit layout loaded into the digit shift register
    typedef enum logic [1:0] {
        NK_DEC,
        NK_HEX,
        NK_PTR
    } t_num_kind;

    typedef struct packed {
        logic      load;
        logic      shift;
        t_num_kind kind;
    } t_sr_ctrl;

    typedef struct packed {
        logic [3:0] digit;
        logic       last;
        logic       skip;
    } t_sr_stat;

    // formatter sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MINUS,
        ST_ZERO,
        ST_X,
        ST_DIGITS
    } t_state;

    // one digit to its ascii character
    function automatic logic [CHAR_BITS-1:0] ascii_digit(input logic [3:0] d,
                                                         input logic upper);
        logic [CHAR_BITS-1:0] ext;
        ext = {4'd0, d};
        if (d < 4'd10) begin
            return ASCII_ZERO + ext;
        end else if (upper) begin
            return ASCII_UC_A + ext - 8'd10;
        end else begin
            return ASCII_LC_A + ext - 8'd10;
        end
    endfunction

endpackage

### sv/iaf_bcd.sv
// ----------------------------------------------------------------------------
// iaf_bcd - bit serial binary to bcd converter
// Shift-and-add-3 conversion of a 32-bit magnitude into ten bcd digits,
// one binary bit per cycle.
// ----------------------------------------------------------------------------
module iaf_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [iaf_pkg::BIN_BITS-1:0]  i_bin,
    output logic                          o_done,
    output logic [iaf_pkg::BCD_BITS-1:0]  o_bcd
);
    import iaf_pkg::*;

    localparam int CntBits = $clog2(BIN_BITS);

    logic [BIN_BITS-1:0] r_bin;
    logic [BCD_BITS-1:0] r_bcd;
    logic [BCD_BITS-1:0] n_adj;
    logic [CntBits-1:0]  r_cnt;
    logic                r_busy;
    logic                r_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] nib;
        nib = 4'd0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            nib = r_bcd[4*i +: 4];
            n_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntBits'(BIN_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, one binary bit into the bcd word per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[BIN_BITS-2:0], 1'b0};
            r_bcd <= {n_adj[BCD_BITS-2:0], r_bin[BIN_BITS-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

### sv/iaf_digit_sr.sv
// ----------------------------------------------------------------------------
// iaf_digit_sr - digit shift register
// Holds the digits of one number left aligned and hands them out most
// significant first, one nibble per shift, flagging leading zeros.
// ----------------------------------------------------------------------------
module iaf_digit_sr #(
    parameter int POINTER_BITS = iaf_pkg::POINTER_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  iaf_pkg::t_sr_ctrl                              i_ctrl,
    input  logic [4*(((POINTER_BITS+3)/4 > iaf_pkg::DEC_DIGITS) ?
                     (POINTER_BITS+3)/4 : iaf_pkg::DEC_DIGITS)-1:0] i_data,
    output iaf_pkg::t_sr_stat                              o_stat
);
    import iaf_pkg::*;

    localparam int PtrDigits = (POINTER_BITS + 3) / 4;
    localparam int NumDigits = (PtrDigits > DEC_DIGITS) ? PtrDigits : DEC_DIGITS;
    localparam int SrBits    = NumDigits * 4;
    localparam int LeftBits  = $clog2(NumDigits + 1);

    logic [SrBits-1:0]   r_sr;
    logic [LeftBits-1:0] r_left;
    logic [LeftBits-1:0] n_load_left;
    logic                r_started;

    // digit count by layout
    always_comb begin
        unique case (i_ctrl.kind)
            NK_DEC:  n_load_left = LeftBits'(DEC_DIGITS);
            NK_HEX:  n_load_left = LeftBits'(HEX_DIGITS);
            NK_PTR:  n_load_left = LeftBits'(PtrDigits);
            default: n_load_left = LeftBits'(DEC_DIGITS);
        endcase
    end

    // status toward the sequencer
    always_comb begin
        o_stat.digit = r_sr[SrBits-1 -: 4];
        o_stat.last  = (r_left == LeftBits'(1));
        o_stat.skip  = !r_started && (r_sr[SrBits-1 -: 4] == 4'd0) &&
                       (r_left != LeftBits'(1));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_started <= 1'b0;
        end else if (i_ctrl.load) begin
            r_left    <= n_load_left;
            r_started <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_left    <= r_left - 1'b1;
            r_started <= r_started | !o_stat.skip;
        end
    end

    // digit storage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sr <= i_data;
        end else if (i_ctrl.shift) begin
            r_sr <= {r_sr[SrBits-5:0], 4'd0};
        end
    end

endmodule

### sv/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter - printf style integer formatter
// Turns one value and a format kind into its ascii characters, most
// significant digit first, with a saturating running character count.
// ----------------------------------------------------------------------------
// Each input word carries a value in tdata and a kind in tuser: 0 signed
// decimal, 1 unsigned decimal, 2 lowercase hex, 3 uppercase hex, 4 pointer
// ("0x" and the low POINTER_BITS bits in lowercase hex); kinds 5 to 7
// produce no output. Each output word is one character with tlast on the
// final one of an item. Decimal kinds first pass through the bit serial
// binary to bcd converter; a negative signed value then gets a minus sign.
// Every kind then walks its digit slots (10 decimal, 8 hex,
// ceil(POINTER_BITS/4) pointer), dropping leading zeros without output.
// One character leaves per cycle while the sink is ready; the next word is
// taken once the last character sits in the output register.
module integer_to_ascii_formatter #(
    parameter int POINTER_BITS = iaf_pkg::POINTER_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [iaf_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,  // value
    input  logic [iaf_pkg::REQ_BITS-1:0]         s_axis_tuser,  // req_type
    // output words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [iaf_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,  // out_char, total_count
    output logic                                 m_axis_tlast   // last_char
);
    import iaf_pkg::*;

    localparam int PtrDigits = (POINTER_BITS + 3) / 4;
    localparam int NumDigits = (PtrDigits > DEC_DIGITS) ? PtrDigits : DEC_DIGITS;
    localparam int SrBits    = NumDigits * 4;

    t_state                r_state, n_state;
    logic                  r_m_valid, n_m_valid;
    logic [CHAR_BITS-1:0]  r_m_char, n_m_char;
    logic                  r_m_last, n_m_last;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_upper, n_upper;
    logic                  r_neg, n_neg;

    logic                  out_free;
    logic                  emit;
    logic [CHAR_BITS-1:0]  emit_char;
    logic                  emit_last;
    logic                  bcd_start;
    logic                  bcd_done;
    logic [BIN_BITS-1:0]   bcd_bin;
    logic [BCD_BITS-1:0]   bcd_word;
    t_sr_ctrl              sr_ctrl;
    t_sr_stat              sr_stat;
    logic [SrBits-1:0]     sr_data;

    // magnitude of a signed or unsigned 32-bit value
    assign bcd_bin = (s_axis_tuser == RK_SDEC && s_axis_tdata[BIN_BITS-1])
                   ? (~s_axis_tdata[BIN_BITS-1:0] + 1'b1)
                   : s_axis_tdata[BIN_BITS-1:0];

    iaf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_bin   (bcd_bin),
        .o_done  (bcd_done),
        .o_bcd   (bcd_word)
    );

    iaf_digit_sr #(
        .POINTER_BITS (POINTER_BITS)
    ) u_digit_sr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sr_ctrl),
        .i_data  (sr_data),
        .o_stat  (sr_stat)
    );

    assign out_free = !r_m_valid || m_axis_tready;

    // sequencer: next state and outputs
    always_comb begin
        n_state   = r_state;
        n_upper   = r_upper;
        n_neg     = r_neg;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_char  = r_m_char;
        n_m_last  = r_m_last;
        n_count   = r_count;
        s_axis_tready = 1'b0;
        bcd_start = 1'b0;
        emit      = 1'b0;
        emit_char = ASCII_ZERO;
        emit_last = 1'b0;
        sr_ctrl   = '{load: 1'b0, shift: 1'b0, kind: NK_DEC};
        sr_data   = SrBits'(bcd_word) << (SrBits - BCD_BITS);

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        RK_SDEC: begin
                            n_neg     = s_axis_tdata[BIN_BITS-1];
                            bcd_start = 1'b1;
                            n_state   = ST_CONV;
                        end
                        RK_UDEC: begin
                            n_neg     = 1'b0;
                            bcd_start = 1'b1;
                            n_state   = ST_CONV;
                        end
                        RK_HEXL, RK_HEXU: begin
                            n_upper      = (s_axis_tuser == RK_HEXU);
                            sr_ctrl.load = 1'b1;
                            sr_ctrl.kind = NK_HEX;
                            sr_data      = SrBits'(s_axis_tdata[BIN_BITS-1:0])
                                           << (SrBits - BIN_BITS);
                            n_state      = ST_DIGITS;
                        end
                        RK_PTR: begin
                            n_upper      = 1'b0;
                            sr_ctrl.load = 1'b1;
                            sr_ctrl.kind = NK_PTR;
                            sr_data      = SrBits'(s_axis_tdata[POINTER_BITS-1:0])
                                           << (SrBits - PtrDigits * 4);
                            n_state      = ST_ZERO;
                        end
                        default: begin
                            // unknown kind, word dropped
                        end
                    endcase
                end
            end
            ST_CONV: begin
                if (bcd_done) begin
                    n_upper      = 1'b0;
                    sr_ctrl.load = 1'b1;
                    sr_ctrl.kind = NK_DEC;
                    n_state      = r_neg ? ST_MINUS : ST_DIGITS;
                end
            end
            ST_MINUS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = ASCII_MINUS;
                    n_state   = ST_DIGITS;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = ASCII_ZERO;
                    n_state   = ST_X;
                end
            end
            ST_X: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = ASCII_X;
                    n_state   = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (sr_stat.skip) begin
                    sr_ctrl.shift = 1'b1;
                end else if (out_free) begin
                    sr_ctrl.shift = 1'b1;
                    emit          = 1'b1;
                    emit_char     = ascii_digit(sr_stat.digit, r_upper);
                    emit_last     = sr_stat.last;
                    if (sr_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase

        // load the output register and bump the count
        if (emit) begin
            n_m_valid = 1'b1;
            n_m_char  = emit_char;
            n_m_last  = emit_last;
            n_count   = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_count   <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_m_char <= n_m_char;
        r_m_last <= n_m_last;
        r_upper  <= n_upper;
        r_neg    <= n_neg;
    end

    // output word
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = OUT_TDATA_BITS'({r_count, r_m_char});

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench of the integer to ascii formatter
// Drives value and format kind words into the stream input and predicts
// every ascii character, its tlast flag and the running character count.
// The check process compares each output word against the oldest
// prediction. Directed corner cases come first, then a backpressure
// burst, then random traffic. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    import iaf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int PTR_BITS     = POINTER_BITS_DEF;
    localparam int RANDOM_ITEMS = 330;
    localparam int BURST_ITEMS  = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    // format kinds that the block must ignore
    localparam logic [REQ_BITS-1:0] KIND_BAD_LO  = 3'd5;
    localparam logic [REQ_BITS-1:0] KIND_BAD_MID = 3'd6;
    localparam logic [REQ_BITS-1:0] KIND_BAD_HI  = 3'd7;

    localparam string DIGITS_LC = "0123456789abcdef";
    localparam string DIGITS_UC = "0123456789ABCDEF";

    // one predicted output word
    typedef struct {
        logic [CHAR_BITS-1:0]  ch;
        logic                  last;
        logic [COUNT_BITS-1:0] count;
    } t_char_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;   // value
    logic [REQ_BITS-1:0]       s_axis_tuser;   // req_type
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;   // out_char, total_count
    logic                      m_axis_tlast;   // last_char

    t_char_word            exp_chars[$];
    logic [COUNT_BITS-1:0] char_total;
    int                    mismatches;
    int                    chars_checked;
    int                    kind_items[5];
    int                    ignored_items;
    int                    cycle_count;
    int                    sink_wait;
    logic                  sink_idle;
    logic                  sink_hold;
    bit                    src_idle;
    event                  hold_start;

    integer_to_ascii_formatter #(
        .POINTER_BITS (PTR_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // cycle counter for the run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_count, exp_chars.size());
        $display("Simulation FAILED");
        $finish;
    end

    // expected characters of one format request, in printing order
    function automatic void predict_chars(input logic [REQ_BITS-1:0]   kind,
                                          input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] base;
        logic [31:0]           low_word;
        logic                  upper;
        logic                  neg;
        logic                  pfx;
        logic [3:0]            digs[$];
        logic [CHAR_BITS-1:0]  txt[$];
        t_char_word            w;
        upper    = 1'b0;
        neg      = 1'b0;
        pfx      = 1'b0;
        low_word = value[31:0];
        case (kind)
            RK_SDEC: begin
                if (low_word[31]) begin
                    neg      = 1'b1;
                    low_word = -low_word;
                end
                mag  = {32'd0, low_word};
                base = 10;
            end
            RK_UDEC: begin
                mag  = {32'd0, low_word};
                base = 10;
            end
            RK_HEXL: begin
                mag  = {32'd0, low_word};
                base = 16;
            end
            RK_HEXU: begin
                mag   = {32'd0, low_word};
                base  = 16;
                upper = 1'b1;
            end
            RK_PTR: begin
                mag  = value & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - PTR_BITS));
                base = 16;
                pfx  = 1'b1;
            end
            default: begin
                ignored_items++;
                return;
            end
        endcase
        kind_items[kind]++;
        if (neg) begin
            txt.push_back(ASCII_MINUS);
        end
        if (pfx) begin
            txt.push_back(ASCII_ZERO);
            txt.push_back(ASCII_X);
        end
        // digits come out least significant first
        do begin
            digs.push_back(4'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        for (int i = digs.size() - 1; i >= 0; i--) begin
            txt.push_back(upper ? DIGITS_UC[digs[i]] : DIGITS_LC[digs[i]]);
        end
        foreach (txt[i]) begin
            if (char_total != COUNT_MAX) begin
                char_total++;
            end
            w.ch    = txt[i];
            w.last  = (i == txt.size() - 1);
            w.count = char_total;
            exp_chars.push_back(w);
        end
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    // sink ready: random wait per word, plus the long hold-off
    always @(posedge i_clk) begin : sink_ctrl
        if (!i_rst_n) begin
            sink_wait = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                sink_wait = sink_idle ? $urandom_range(0, 9) : 0;
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_axis_tready <= (sink_wait == 0) && !sink_hold;
        end
    end

    // long hold-off of the sink, counted here
    initial begin
        sink_hold <= 1'b0;
        forever begin
            @(hold_start);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            sink_hold <= 1'b0;
        end
    end

    // compare each output word with the oldest prediction
    always @(posedge i_clk) begin : char_check
        t_char_word            want;
        logic [CHAR_BITS-1:0]  got_ch;
        logic [COUNT_BITS-1:0] got_cnt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_ch  = m_axis_tdata[CHAR_BITS-1:0];
            got_cnt = m_axis_tdata[CHAR_BITS +: COUNT_BITS];
            chars_checked++;
            if (exp_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word char %h last %b count %0d",
                                          got_ch, m_axis_tlast, got_cnt));
            end else begin
                want = exp_chars.pop_front();
                if (got_ch !== want.ch) begin
                    report_mismatch($sformatf("char expected %h got %h",
                                              want.ch, got_ch));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("tlast expected %b got %b (char %h)",
                                              want.last, m_axis_tlast, want.ch));
                end
                if (got_cnt !== want.count) begin
                    report_mismatch($sformatf("count expected %0d got %0d",
                                              want.count, got_cnt));
                end
            end
        end
    end

    // offer one request and wait until it is taken; tvalid stays high
    task automatic send_req(input logic [REQ_BITS-1:0]   kind,
                            input logic [VALUE_BITS-1:0] value);
        int gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_chars(kind, value);
    endtask

    // stop offering and wait for every predicted word
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random value with a bias toward short and boundary numbers
    function automatic logic [VALUE_BITS-1:0] rand_value;
        logic [VALUE_BITS-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = {$urandom, 32'($urandom_range(0, 20))};
            1: v = {$urandom, -32'($urandom_range(1, 20))};
            2: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            4: v = {VALUE_BITS{1'b1}};
            default: ;
        endcase
        return v;
    endfunction

    // legal kinds most of the time, ignored kinds now and then
    task automatic send_random;
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 14) begin
            send_req(REQ_BITS'(pick % 5), rand_value());
        end else begin
            send_req(REQ_BITS'($urandom_range(KIND_BAD_LO, KIND_BAD_HI)), rand_value());
        end
    endtask

    task automatic test_signed_decimal;
        send_req(RK_SDEC, 64'd0);
        send_req(RK_SDEC, 64'd1);
        send_req(RK_SDEC, 64'h0000_0000_7FFF_FFFF);
        send_req(RK_SDEC, 64'h0000_0000_FFFF_FFFF);
        send_req(RK_SDEC, 64'h0000_0000_8000_0000);
        send_req(RK_SDEC, 64'hFFFF_FFFF_0000_0009);
        drain();
    endtask

    task automatic test_unsigned_decimal;
        send_req(RK_UDEC, 64'd0);
        send_req(RK_UDEC, 64'h0000_0000_FFFF_FFFF);
        send_req(RK_UDEC, 64'hFFFF_FFFF_0000_0000);
        send_req(RK_UDEC, 64'd1000000000);
        drain();
    endtask

    task automatic test_hex;
        send_req(RK_HEXL, 64'd0);
        send_req(RK_HEXL, 64'h0000_0000_DEAD_BEEF);
        send_req(RK_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(RK_HEXU, 64'h5A5A_5A5A_ABCD_EF01);
        send_req(RK_HEXU, 64'h0000_0000_0000_000F);
        drain();
    endtask

    task automatic test_pointer;
        send_req(RK_PTR, 64'd0);
        send_req(RK_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(RK_PTR, 64'h0123_4567_89AB_CDEF);
        send_req(RK_PTR, 64'h8000_0000_0000_0000);
        drain();
    endtask

    // ignored kinds must leave no words and no count behind
    task automatic test_ignored_kinds;
        send_req(KIND_BAD_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(RK_UDEC, 64'd7);
        send_req(KIND_BAD_MID, 64'h0000_0000_8000_0000);
        send_req(KIND_BAD_HI, 64'd12345);
        send_req(RK_HEXL, 64'hA);
        drain();
    endtask

    // sink holds off while requests keep coming, so the input stalls
    task automatic test_backpressure;
        src_idle  = 1'b0;
        sink_idle <= 1'b0;
        -> hold_start;
        for (int i = 0; i < BURST_ITEMS; i++) begin
            send_req(REQ_BITS'(i % 5), rand_value());
        end
        drain();
    endtask

    // random traffic, idling pattern changes every stretch of requests
    task automatic test_random;
        int legal_sent;
        int mode;
        legal_sent = 0;
        while (legal_sent < RANDOM_ITEMS) begin
            if (legal_sent % 40 == 0) begin
                mode      = $urandom_range(0, 3);
                src_idle  = mode[0];
                sink_idle <= mode[1];
            end
            if ($urandom_range(0, 15) < 14) begin
                send_req(REQ_BITS'($urandom_range(0, 4)), rand_value());
                legal_sent++;
            end else begin
                send_random();
            end
        end
        drain();
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        sink_idle     <= 1'b1;
        i_rst_n       <= 1'b0;
        src_idle      = 1'b1;
        char_total    = '0;
        mismatches    = 0;
        chars_checked = 0;
        ignored_items = 0;
        foreach (kind_items[i]) kind_items[i] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_signed_decimal();
        test_unsigned_decimal();
        test_hex();
        test_pointer();
        test_ignored_kinds();
        test_backpressure();
        test_random();

        if (exp_chars.size() != 0) begin
            mismatches++;
            $display("%0d expected words never arrived", exp_chars.size());
        end
        $display("covered %0d signed, %0d unsigned, %0d hex lower, %0d hex upper, %0d pointer",
                 kind_items[RK_SDEC], kind_items[RK_UDEC], kind_items[RK_HEXL],
                 kind_items[RK_HEXU], kind_items[RK_PTR]);
        $display("plus %0d ignored kinds; %0d characters checked, %0d mismatches",
                 ignored_items, chars_checked, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
